// ===== hdl/msbs_pkg.sv =====
// shared types, codes and defaults for the multi-signature byte scanner
`timescale 1ns / 1ps

package msbs_pkg;

   localparam int NUM_SIGS_DEF       = 16;
   localparam int MAX_SIG_LEN_DEF    = 64;
   localparam int MAX_SCAN_BYTES_DEF = 65536;

   // most results one scanned byte can raise
   localparam int RESULT_CAP = 16;

   localparam logic [1:0] CMD_SIG_BYTE = 2'd0;
   localparam logic [1:0] CMD_SIG_LEN  = 2'd1;
   localparam logic [1:0] CMD_RESTART  = 2'd2;
   localparam logic [1:0] CMD_SCAN     = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] slot;
      logic [5:0] sig_pos;
      logic [6:0] sig_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] match_start;
      logic [3:0]  match_slot;
      logic [6:0]  match_length;
      logic        last_match;
   } rsp_type;

   // control from the sequencer to every cell of the row
   typedef struct packed {
      logic shift;
      logic sig_we;
   } cell_ctrl_type;

endpackage

// ===== hdl/msbs_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module msbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/msbs_cell.sv =====
// one byte lane: history byte, its signature column and the byte compare
`timescale 1ns / 1ps

module msbs_cell #(
   parameter int IDX         = 0,
   parameter int NUM_SIGS    = msbs_pkg::NUM_SIGS_DEF,
   parameter int MAX_SIG_LEN = msbs_pkg::MAX_SIG_LEN_DEF,
   localparam int SA_W  = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1,
   localparam int LEN_W = $clog2(MAX_SIG_LEN + 1)
) (
   input  logic                    clock,
   input  msbs_pkg::cell_ctrl_type ctrl,
   input  logic [5:0]              sig_pos,
   input  logic [SA_W-1:0]         waddr,
   input  logic [7:0]              wdata,
   input  logic [SA_W-1:0]         raddr,
   input  logic [7:0]              hist_in,
   output logic [7:0]              hist_out,
   input  logic [7:0]              cmp_byte,
   input  logic [LEN_W-1:0]        cmp_len,
   output logic                    eq
);

   logic [7:0] hist_ff;
   logic [7:0] sig_byte;
   logic       col_we;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         hist_ff <= hist_in;
      end
   end

   assign col_we = ctrl.sig_we && ({26'd0, sig_pos} == 32'(IDX));

   msbs_ram #(
      .WIDTH (8),
      .DEPTH (NUM_SIGS)
   ) u_col (
      .clock (clock),
      .we    (col_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (sig_byte)
   );

   // lanes past the signature length always agree
   assign eq = (sig_byte == cmp_byte) ||
               (32'(IDX) >= {{(32-LEN_W){1'b0}}, cmp_len});

   assign hist_out = hist_ff;

endmodule

// ===== hdl/multi_signature_byte_scan.sv =====
// top level: command decode, slot sequencer, row of byte cells, result drain
//
//  port group | dir | handshake          | carries
//  req_       | in  | req_valid/ready    | msbs_pkg::req_type command word
//  rsp_       | out | rsp_valid/ready    | msbs_pkg::rsp_type match word
//  csr_       | in  | csr_valid/ready    | active_slots (5 bits)
//
// signature writes and restart are taken in idle and leave req_ready high
// a scanned byte holds req_ready low while limit slots are checked, limit = min(active_slots, NUM_SIGS, 16):
// one slot per cycle through the length table, column rams and aligner
// then its matches go to the output register, lowest slot first, as the register frees
// synchronous reset clears position, lengths, active_slots and control
// req_ready is low while a byte is scanned or its matches are handed to the output register

`timescale 1ns / 1ps

module multi_signature_byte_scan #(
   parameter int NUM_SIGS       = msbs_pkg::NUM_SIGS_DEF,
   parameter int MAX_SIG_LEN    = msbs_pkg::MAX_SIG_LEN_DEF,
   parameter int MAX_SCAN_BYTES = msbs_pkg::MAX_SCAN_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msbs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   localparam int SA_W  = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
   localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);
   localparam int POS_W = $clog2(MAX_SCAN_BYTES + 1);
   localparam int CAP   = msbs_pkg::RESULT_CAP;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [4:0]              active_ff, active_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [LEN_W-1:0]        len_ff [NUM_SIGS];
   logic [4:0]              scnt_ff, scnt_in;
   logic                    va_ff, va_in;
   logic [3:0]              slot_b_ff;
   logic [LEN_W-1:0]        len_b_ff;
   logic                    lok_b_ff;
   logic [8*MAX_SIG_LEN-1:0] aligned_ff;
   logic [CAP-1:0]          vec_ff, vec_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   msbs_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    req_fire;
   logic                    scan_go;
   logic [4:0]              limit;
   logic [31:0]             lim32;
   msbs_pkg::cell_ctrl_type ctrl;
   logic [SA_W+3:0]         slot_ext;
   logic [SA_W+4:0]         scnt_ext;
   logic [SA_W+3:0]         emit_ext;
   logic [SA_W-1:0]         wslot;
   logic [SA_W-1:0]         len_raddr;
   logic [LEN_W-1:0]        len_rd;
   logic [LEN_W+6:0]        wlen_ext;
   logic [LEN_W-1:0]        sh;
   logic [7:0]              hist_w [MAX_SIG_LEN];
   logic [MAX_SIG_LEN-1:0]  eq_w;
   logic [8*MAX_SIG_LEN-1:0] rev_vec;
   logic [CAP-1:0]          low_hot;
   logic [3:0]              emit_idx;
   logic                    emit_last;
   logic                    emit_load;
   logic [31:0]             start32;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign scan_go   = req_fire && (req_data.cmd == msbs_pkg::CMD_SCAN) &&
                      ({{(32-POS_W){1'b0}}, pos_ff} < 32'(MAX_SCAN_BYTES));

   always_comb begin
      lim32 = {27'd0, active_ff};
      if (lim32 > 32'(NUM_SIGS)) begin
         lim32 = 32'(NUM_SIGS);
      end
      if (lim32 > 32'(CAP)) begin
         lim32 = 32'(CAP);
      end
      limit = lim32[4:0];
   end

   assign slot_ext = {{SA_W{1'b0}}, req_data.slot};
   assign wslot    = slot_ext[SA_W-1:0];
   assign wlen_ext = {{LEN_W{1'b0}}, req_data.sig_length};

   assign ctrl.shift  = scan_go;
   assign ctrl.sig_we = req_fire && (req_data.cmd == msbs_pkg::CMD_SIG_BYTE) &&
                        ({28'd0, req_data.slot} < 32'(NUM_SIGS)) &&
                        ({26'd0, req_data.sig_pos} < 32'(MAX_SIG_LEN));

   // low-slot-first pick over the match vector
   assign low_hot   = vec_ff & (~vec_ff + CAP'(1));
   assign emit_last = ((vec_ff & (vec_ff - CAP'(1))) == '0);
   always_comb begin
      emit_idx = '0;
      for (int i = 0; i < CAP; i++) begin
         if (low_hot[i]) begin
            emit_idx = emit_idx | 4'(i);
         end
      end
   end

   assign scnt_ext = {{SA_W{1'b0}}, scnt_ff};
   assign emit_ext = {{SA_W{1'b0}}, emit_idx};
   assign len_raddr = (state_ff == ST_SCAN) ? scnt_ext[SA_W-1:0] : emit_ext[SA_W-1:0];
   assign len_rd    = len_ff[len_raddr];

   // cell row: history moves one lane per scanned byte, lane k holds age k
   for (genvar k = 0; k < MAX_SIG_LEN; k++) begin : g_cell
      logic [7:0] hist_src;
      if (k == 0) begin : g_head
         assign hist_src = req_data.data_byte;
      end else begin : g_body
         assign hist_src = hist_w[k-1];
      end
      msbs_cell #(
         .IDX         (k),
         .NUM_SIGS    (NUM_SIGS),
         .MAX_SIG_LEN (MAX_SIG_LEN)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .sig_pos  (req_data.sig_pos),
         .waddr    (wslot),
         .wdata    (req_data.data_byte),
         .raddr    (scnt_ext[SA_W-1:0]),
         .hist_in  (hist_src),
         .hist_out (hist_w[k]),
         .cmp_byte (aligned_ff[8*k +: 8]),
         .cmp_len  (len_b_ff),
         .eq       (eq_w[k])
      );
      assign rev_vec[8*k +: 8] = hist_w[MAX_SIG_LEN-1-k];
   end

   // signature byte k lines up with age len-1-k
   assign sh = LEN_W'(MAX_SIG_LEN) - len_rd;

   assign start32 = {{(32-POS_W){1'b0}}, pos_ff} - {{(32-LEN_W){1'b0}}, len_rd};

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      scnt_in      = scnt_ff;
      va_in        = 1'b0;
      vec_in       = vec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      emit_load    = 1'b0;

      if (csr_valid) begin
         active_in = csr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.cmd == msbs_pkg::CMD_RESTART)) begin
               pos_in = '0;
            end
            if (scan_go) begin
               pos_in   = pos_ff + POS_W'(1);
               scnt_in  = '0;
               vec_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scnt_ff < limit) begin
               va_in   = 1'b1;
               scnt_in = scnt_ff + 5'd1;
            end
            if (va_ff && (&eq_w) && lok_b_ff) begin
               vec_in[slot_b_ff] = 1'b1;
            end
            if (!(scnt_ff < limit) && !va_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (vec_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               emit_load            = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.match_start   = start32[15:0];
               rsp_in.match_slot    = emit_idx;
               rsp_in.match_length  = 7'(len_rd);
               rsp_in.last_match    = emit_last;
               vec_in               = vec_ff & ~low_hot;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         pos_ff       <= '0;
         scnt_ff      <= '0;
         va_ff        <= 1'b0;
         vec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SIGS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         scnt_ff      <= scnt_in;
         va_ff        <= va_in;
         vec_ff       <= vec_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && (req_data.cmd == msbs_pkg::CMD_SIG_LEN) &&
             ({28'd0, req_data.slot} < 32'(NUM_SIGS)) &&
             ({25'd0, req_data.sig_length} <= 32'(MAX_SIG_LEN))) begin
            len_ff[wslot] <= wlen_ext[LEN_W-1:0];
         end
      end
   end

   // slot pipeline payload
   always_ff @(posedge clock) begin
      slot_b_ff  <= scnt_ff[3:0];
      len_b_ff   <= len_rd;
      lok_b_ff   <= (len_rd != '0) &&
                    ({{(32-LEN_W){1'b0}}, len_rd} <= {{(32-POS_W){1'b0}}, pos_ff});
      aligned_ff <= rev_vec >> {sh, 3'b000};
      if (emit_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      {{(32-POS_W){1'b0}}, pos_ff} <= 32'(MAX_SCAN_BYTES))
      else $error("scan position beyond budget");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> (state_ff == ST_SCAN))
      else $error("slot compare outside scan");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scnt_ff <= limit))
      else $error("slot counter past limit");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (vec_ff == '0))
      else $error("matches left undelivered");

endmodule
